// ===== rtl/core/kmss_pkg.sv =====
// ----------------------------------------------------------------------------
// kmss_pkg
// Shared types and constants of the key matrix switch-mode scanner.
// ----------------------------------------------------------------------------
package kmss_pkg;

    localparam int NUM_KEYS    = 32;
    localparam int ROW_W       = 4;
    localparam int KEY_W       = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_EVENT   = 2'd0,
        KIND_LEARN   = 2'd1,
        KIND_ADVANCE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CFG_LEARN_MODE      = 3'd0,
        CFG_KEY_HAS_EVENT   = 3'd1,
        CFG_PAIR_ENABLE     = 3'd2,
        CFG_KEY_MODES       = 3'd3,
        CFG_POLARITY_INVERT = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_FOLLOW   = 2'd1,
        MODE_ONE_SIDE = 2'd2,
        MODE_FLIP     = 2'd3
    } t_mode;

    typedef struct packed {
        logic        learn_mode;
        logic [31:0] key_has_event;
        logic [15:0] pair_enable;
        logic [63:0] key_modes;
        logic [31:0] polarity_invert;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] diff;
        logic [KEY_W-1:0] base;
        logic [2:0]       next_col;
        logic             scan_done;
    } t_cmd;

endpackage

// ===== rtl/core/key_matrix_switch_mode_scanner_core.sv =====
// ----------------------------------------------------------------------------
// key_matrix_switch_mode_scanner_core
// Key matrix scanner: classify front, command queue, execute back.
// ----------------------------------------------------------------------------
// Flow: a taken item is written to the command queue, popped into the execute
// unit's command register, and its row results, then the column result, are
// registered for output. The execute unit steps one row per cycle while the
// output is not stalled; the front keeps queueing items meanwhile until full.
// Reset (synchronous, active low) clears configuration, row memory, key
// states, column and scan flag directly; no clearing pass.
// ----------------------------------------------------------------------------
module key_matrix_switch_mode_scanner_core #(
    parameter int NUM_COLUMNS = 8,
    parameter int NUM_ROWS    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_row_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [5:0]  o_key_number,
    output logic        o_on_off,
    output logic        o_key_state,
    output logic [2:0]  o_next_column,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    kmss_pkg::t_cfg r_cfg, n_cfg;
    kmss_pkg::t_cmd push_cmd, head_cmd;
    logic           push, pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (kmss_pkg::t_cfg_idx'(i_cfg_index))
                kmss_pkg::CFG_LEARN_MODE:      n_cfg.learn_mode      = i_cfg_data[0];
                kmss_pkg::CFG_KEY_HAS_EVENT:   n_cfg.key_has_event   = i_cfg_data[31:0];
                kmss_pkg::CFG_PAIR_ENABLE:     n_cfg.pair_enable     = i_cfg_data[15:0];
                kmss_pkg::CFG_KEY_MODES:       n_cfg.key_modes       = i_cfg_data;
                kmss_pkg::CFG_POLARITY_INVERT: n_cfg.polarity_invert = i_cfg_data[31:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    kmss_front #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_row_bits (i_row_bits),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    kmss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    kmss_back #(
        .NUM_ROWS (NUM_ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_empty     (q_empty),
        .i_q_head      (head_cmd),
        .o_q_pop       (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_key_number  (o_key_number),
        .o_on_off      (o_on_off),
        .o_key_state   (o_key_state),
        .o_next_column (o_next_column),
        .o_last        (o_last)
    );

endmodule

// ===== rtl/core/kmss_queue.sv =====
// ----------------------------------------------------------------------------
// kmss_queue
// Short command queue between the classify front and the execute back.
// ----------------------------------------------------------------------------
module kmss_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kmss_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output kmss_pkg::t_cmd  o_head
);

    kmss_pkg::t_cmd                    r_mem [kmss_pkg::QUEUE_DEPTH];
    logic [kmss_pkg::QPTR_W-1:0]       r_wp, n_wp;
    logic [kmss_pkg::QPTR_W-1:0]       r_rp, n_rp;
    logic [kmss_pkg::QCNT_W-1:0]       r_cnt, n_cnt;

    assign o_full  = (r_cnt == kmss_pkg::QCNT_W'(kmss_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/kmss_front.sv =====
// ----------------------------------------------------------------------------
// kmss_front
// Accepts row samples, compares them with the stored row of the driven
// column and queues a command for the execute unit.
// ----------------------------------------------------------------------------
module kmss_front #(
    parameter int NUM_COLUMNS = 8,
    parameter int NUM_ROWS    = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [kmss_pkg::ROW_W-1:0]   i_row_bits,
    input  logic                         i_q_full,
    output logic                         o_push,
    output kmss_pkg::t_cmd               o_cmd
);

    localparam int ROWS_EFF = (NUM_ROWS < kmss_pkg::ROW_W) ? NUM_ROWS : kmss_pkg::ROW_W;
    localparam int CW       = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam logic [kmss_pkg::ROW_W-1:0] ROW_MASK = kmss_pkg::ROW_W'((1 << ROWS_EFF) - 1);

    logic [kmss_pkg::ROW_W-1:0] r_row_mem [NUM_COLUMNS];
    logic [CW-1:0]              r_col, n_col;
    logic                       r_scan_done, n_scan_done;
    logic [kmss_pkg::ROW_W-1:0] row;
    logic [3:0]                 n_col_ext;
    logic                       wrap;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        row         = i_row_bits & ROW_MASK;
        wrap        = (r_col == CW'(NUM_COLUMNS - 1));
        n_col       = wrap ? '0 : r_col + 1'b1;
        n_scan_done = r_scan_done | wrap;
        n_col_ext   = 4'(n_col);

        o_cmd.row       = row;
        o_cmd.diff      = row ^ r_row_mem[r_col];
        o_cmd.base      = kmss_pkg::KEY_W'(r_col) * kmss_pkg::KEY_W'(NUM_ROWS);
        o_cmd.next_col  = n_col_ext[2:0];
        o_cmd.scan_done = r_scan_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_scan_done <= 1'b0;
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                r_row_mem[c] <= '0;
            end
        end else if (o_push) begin
            r_col            <= n_col;
            r_scan_done      <= n_scan_done;
            r_row_mem[r_col] <= row;
        end
    end

endmodule

// ===== rtl/core/kmss_back.sv =====
// ----------------------------------------------------------------------------
// kmss_back
// Execute unit: walks all rows of one command, resolves key modes of the
// changed ones, updates key output states and drives the result register.
// ----------------------------------------------------------------------------
module kmss_back #(
    parameter int NUM_ROWS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kmss_pkg::t_cfg                i_cfg,
    input  logic                          i_q_empty,
    input  kmss_pkg::t_cmd                i_q_head,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_kind,
    output logic [5:0]                    o_key_number,
    output logic                          o_on_off,
    output logic                          o_key_state,
    output logic [2:0]                    o_next_column,
    output logic                          o_last
);

    localparam int ROWS_EFF = (NUM_ROWS < kmss_pkg::ROW_W) ? NUM_ROWS : kmss_pkg::ROW_W;
    localparam int IW       = $clog2(ROWS_EFF + 1);

    logic                           r_busy, n_busy;
    kmss_pkg::t_cmd                 r_cmd, n_cmd;
    logic [IW-1:0]                  r_idx, n_idx;
    logic [kmss_pkg::NUM_KEYS-1:0]  r_key_st, n_key_st;
    logic                           r_o_valid, n_o_valid;
    kmss_pkg::t_kind                r_o_kind, n_o_kind;
    logic [5:0]                     r_o_key, n_o_key;
    logic                           r_o_on, n_o_on;
    logic                           r_o_st, n_o_st;
    logic [2:0]                     r_o_col, n_o_col;
    logic                           r_o_last, n_o_last;

    logic                           out_free, step, at_end;
    logic [kmss_pkg::ROW_W-1:0]     diff_sh, row_sh;
    logic                           changed, press;
    logic [kmss_pkg::KEY_W-1:0]     key, key_p1;
    logic [4:0]                     key5, owner;
    logic                           in_range, paired, handled;
    kmss_pkg::t_mode                mode;
    logic                           pol;
    logic                           produce, new_st, ev_on;

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_key_number  = r_o_key;
    assign o_on_off      = r_o_on;
    assign o_key_state   = r_o_st;
    assign o_next_column = r_o_col;
    assign o_last        = r_o_last;

    always_comb begin
        out_free = !r_o_valid || !i_stall;
        step     = r_busy && out_free;
        at_end   = (r_idx == IW'(ROWS_EFF));
        o_q_pop  = !i_q_empty && (!r_busy || (step && at_end));

        diff_sh  = r_cmd.diff >> r_idx;
        row_sh   = r_cmd.row >> r_idx;
        changed  = diff_sh[0];
        press    = row_sh[0];
        key      = r_cmd.base + kmss_pkg::KEY_W'(r_idx);
        key_p1   = key + kmss_pkg::KEY_W'(1);
        key5     = key[4:0];
        in_range = (key < kmss_pkg::KEY_W'(kmss_pkg::NUM_KEYS));
        paired   = i_cfg.key_has_event[{key5[4:1], 1'b0}] && i_cfg.pair_enable[key5[4:1]];
        handled  = in_range && (paired || i_cfg.key_has_event[key5]);
        owner    = paired ? {key5[4:1], 1'b0} : key5;
        mode     = kmss_pkg::t_mode'(i_cfg.key_modes[{key5, 1'b0} +: 2]);
        pol      = i_cfg.polarity_invert[key5];

        produce = 1'b0;
        new_st  = r_key_st[owner];
        ev_on   = press;
        if (handled) begin
            if (paired) begin
                produce = press;
                new_st  = ~key5[0];
                ev_on   = ~key5[0];
            end else begin
                case (mode)
                    kmss_pkg::MODE_FOLLOW: begin
                        produce = 1'b1;
                        new_st  = press ^ pol;
                        ev_on   = press ^ pol;
                    end
                    kmss_pkg::MODE_ONE_SIDE: begin
                        produce = press;
                        new_st  = ~pol;
                        ev_on   = ~pol;
                    end
                    kmss_pkg::MODE_FLIP: begin
                        produce = press;
                        new_st  = ~r_key_st[owner];
                        ev_on   = ~r_key_st[owner];
                    end
                    default: begin
                        produce = 1'b0;
                    end
                endcase
            end
        end

        n_busy    = r_busy;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_key_st  = r_key_st;
        n_o_valid = r_o_valid && i_stall;
        n_o_kind  = r_o_kind;
        n_o_key   = r_o_key;
        n_o_on    = r_o_on;
        n_o_st    = r_o_st;
        n_o_col   = r_o_col;
        n_o_last  = r_o_last;

        if (step) begin
            if (at_end) begin
                n_busy    = 1'b0;
                n_o_valid = 1'b1;
                n_o_kind  = kmss_pkg::KIND_ADVANCE;
                n_o_key   = '0;
                n_o_on    = 1'b0;
                n_o_st    = 1'b0;
                n_o_col   = r_cmd.next_col;
                n_o_last  = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
                if (changed) begin
                    if (i_cfg.learn_mode) begin
                        n_o_valid = 1'b1;
                        n_o_kind  = kmss_pkg::KIND_LEARN;
                        n_o_key   = key_p1[5:0];
                        n_o_on    = 1'b0;
                        n_o_st    = 1'b0;
                        n_o_col   = '0;
                        n_o_last  = 1'b0;
                    end else if (produce) begin
                        n_key_st[owner] = new_st;
                        if (r_cmd.scan_done) begin
                            n_o_valid = 1'b1;
                            n_o_kind  = kmss_pkg::KIND_EVENT;
                            n_o_key   = 6'(owner);
                            n_o_on    = ev_on;
                            n_o_st    = new_st;
                            n_o_col   = '0;
                            n_o_last  = 1'b0;
                        end
                    end
                end
            end
        end

        if (o_q_pop) begin
            n_busy = 1'b1;
            n_cmd  = i_q_head;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_key_st  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_idx     <= n_idx;
            r_key_st  <= n_key_st;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_o_kind <= n_o_kind;
        r_o_key  <= n_o_key;
        r_o_on   <= n_o_on;
        r_o_st   <= n_o_st;
        r_o_col  <= n_o_col;
        r_o_last <= n_o_last;
    end

endmodule
